// ===== hw/rtl/disjoint_interval_set_top_assert.svh =====
// Assertion macros for the disjoint interval set block.
// Used by disjoint_interval_set_top; expects clk_i and rst_ni in scope.
`ifndef DISJOINT_INTERVAL_SET_TOP_ASSERT_SVH
`define DISJOINT_INTERVAL_SET_TOP_ASSERT_SVH

// Same-cycle implication.
`define DIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define DIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/dis_pkg.sv =====
// Shared constants, status codes and controller/datapath interface types
// for the disjoint interval set block. No dependencies.
`timescale 1ns / 1ps

package dis_pkg;

  localparam int unsigned MaxIntervals = 32;
  localparam int unsigned ValueBits    = 16;
  localparam int unsigned IdxW         = $clog2(MaxIntervals);
  localparam int unsigned CntW         = $clog2(MaxIntervals + 1);

  localparam logic [2:0] ST_PRESENT  = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_EXT_LOW  = 3'd2;
  localparam logic [2:0] ST_EXT_HIGH = 3'd3;
  localparam logic [2:0] ST_MERGED   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_LIST     = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_LIST = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_UPD  = 4'b0100,
    S_LIST = 4'b1000
  } ctrl_state_e;

  typedef struct packed {
    logic capture;    // take the input transfer
    logic decide;     // register the compare result
    logic commit;     // update the table and present the add result
    logic list_load;  // present the next listed interval
  } dp_cmd_t;

  typedef struct packed {
    logic            is_list;
    logic            out_free;
    logic            list_done;
    logic [CntW-1:0] count;
  } dp_sts_t;

endpackage

// ===== hw/rtl/dis_ctrl.sv =====
// Controller state machine of the disjoint interval set block.
// Depends on dis_pkg; drives dis_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module dis_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dis_pkg::dp_sts_t sts_i,
  output dis_pkg::dp_cmd_t cmd_o
);
  import dis_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.is_list ? S_LIST : S_UPD;
      end
      S_UPD: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts_i.out_free) begin
          cmd_o.list_load = 1'b1;
          if (sts_i.list_done) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/dis_datapath.sv =====
// Datapath of the disjoint interval set block: interval table, parallel
// compare, shift update and output register. Depends on dis_pkg.
`timescale 1ns / 1ps

module dis_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dis_pkg::dp_cmd_t              cmd_i,
  output dis_pkg::dp_sts_t              sts_o,
  input  logic                          in_cmd_i,
  input  logic [dis_pkg::ValueBits-1:0] in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    out_status_o,
  output logic [dis_pkg::ValueBits-1:0] out_low_o,
  output logic [dis_pkg::ValueBits-1:0] out_high_o,
  output logic [dis_pkg::CntW-1:0]      out_count_o,
  output logic                          out_last_o
);
  import dis_pkg::*;

  localparam logic [ValueBits-1:0] VMax = '1;

  logic [ValueBits-1:0] lo_q [MaxIntervals];
  logic [ValueBits-1:0] hi_q [MaxIntervals];
  logic [CntW-1:0]      count_q, count_d;
  logic                 cmd_q;
  logic [ValueBits-1:0] val_q;
  logic [2:0]           st_q, st_d;
  logic [CntW-1:0]      p_q, p_d;
  logic [ValueBits-1:0] rlo_q, rlo_d, rhi_q, rhi_d;
  logic [IdxW-1:0]      idx_q;

  logic                 ov_q;
  logic [2:0]           ost_q;
  logic [ValueBits-1:0] olo_q, ohi_q;
  logic [CntW-1:0]      ocnt_q;
  logic                 olast_q;

  logic [MaxIntervals-1:0] le, nx, pv;
  logic [ValueBits-1:0]    prev_lo, prev_hi, next_lo, next_hi;
  logic                    has_prev, has_next, present, adj_lo, adj_hi;
  logic                    out_free;

  // Parallel compare against every stored entry; entries are sorted, so le
  // is a run of ones from entry zero.
  always_comb begin
    for (int i = 0; i < MaxIntervals; i++) begin
      le[i] = (CntW'(i) < count_q) && (lo_q[i] <= val_q);
    end
    for (int i = 0; i < MaxIntervals; i++) begin
      pv[i] = le[i] && ((i == MaxIntervals - 1) ? 1'b1 : !le[(i + 1) % MaxIntervals]);
      nx[i] = (CntW'(i) < count_q) && !le[i] &&
              ((i == 0) ? 1'b1 : le[(i + MaxIntervals - 1) % MaxIntervals]);
    end
    prev_lo = '0;
    prev_hi = '0;
    next_lo = '0;
    next_hi = '0;
    p_d     = count_q;
    for (int i = 0; i < MaxIntervals; i++) begin
      prev_lo = prev_lo | (lo_q[i] & {ValueBits{pv[i]}});
      prev_hi = prev_hi | (hi_q[i] & {ValueBits{pv[i]}});
      next_lo = next_lo | (lo_q[i] & {ValueBits{nx[i]}});
      next_hi = next_hi | (hi_q[i] & {ValueBits{nx[i]}});
      if (nx[i]) begin
        p_d = CntW'(i);
      end
    end
    has_prev = le[0];
    has_next = |nx;
    present  = has_prev && (prev_hi >= val_q);
    adj_lo   = has_prev && (prev_hi != VMax) && (prev_hi + 1'b1 == val_q);
    adj_hi   = has_next && (next_lo - 1'b1 == val_q);

    if (present) begin
      st_d = ST_PRESENT;  rlo_d = prev_lo; rhi_d = prev_hi;
    end else if (adj_lo && adj_hi) begin
      st_d = ST_MERGED;   rlo_d = prev_lo; rhi_d = next_hi;
    end else if (adj_lo) begin
      st_d = ST_EXT_LOW;  rlo_d = prev_lo; rhi_d = val_q;
    end else if (adj_hi) begin
      st_d = ST_EXT_HIGH; rlo_d = val_q;   rhi_d = next_hi;
    end else if (count_q >= CntW'(MaxIntervals)) begin
      st_d = ST_FULL;     rlo_d = val_q;   rhi_d = val_q;
    end else begin
      st_d = ST_NEW;      rlo_d = val_q;   rhi_d = val_q;
    end
  end

  always_comb begin
    case (st_q)
      ST_MERGED: count_d = count_q - 1'b1;
      ST_NEW:    count_d = count_q + 1'b1;
      default:   count_d = count_q;
    endcase
  end

  // Table update: each entry takes its own value, a neighbour's or the new one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < MaxIntervals; i++) begin
        case (st_q)
          ST_MERGED: begin
            if (CntW'(i + 1) == p_q) begin
              hi_q[i] <= rhi_q;
            end else if (CntW'(i) >= p_q && i < MaxIntervals - 1) begin
              lo_q[i] <= lo_q[(i + 1) % MaxIntervals];
              hi_q[i] <= hi_q[(i + 1) % MaxIntervals];
            end
          end
          ST_EXT_LOW: begin
            if (CntW'(i + 1) == p_q) begin
              hi_q[i] <= val_q;
            end
          end
          ST_EXT_HIGH: begin
            if (CntW'(i) == p_q) begin
              lo_q[i] <= val_q;
            end
          end
          ST_NEW: begin
            if (CntW'(i) == p_q) begin
              lo_q[i] <= val_q;
              hi_q[i] <= val_q;
            end else if (CntW'(i) > p_q) begin
              lo_q[i] <= lo_q[(i + MaxIntervals - 1) % MaxIntervals];
              hi_q[i] <= hi_q[(i + MaxIntervals - 1) % MaxIntervals];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= in_cmd_i;
      val_q <= in_value_i;
    end
    if (cmd_i.decide) begin
      st_q  <= st_d;
      p_q   <= p_d;
      rlo_q <= rlo_d;
      rhi_q <= rhi_d;
    end
    if (cmd_i.commit) begin
      ost_q   <= st_q;
      olo_q   <= rlo_q;
      ohi_q   <= rhi_q;
      ocnt_q  <= count_d;
      olast_q <= 1'b1;
    end else if (cmd_i.list_load) begin
      ocnt_q  <= count_q;
      olast_q <= sts_o.list_done;
      if (count_q == '0) begin
        ost_q <= ST_EMPTY;
        olo_q <= '0;
        ohi_q <= '0;
      end else begin
        ost_q <= ST_LIST;
        olo_q <= lo_q[idx_q];
        ohi_q <= hi_q[idx_q];
      end
    end
  end

  assign out_free = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q <= count_d;
      end
      if (cmd_i.decide) begin
        idx_q <= '0;
      end else if (cmd_i.list_load) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.commit || cmd_i.list_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_list   = (cmd_q == CMD_LIST);
  assign sts_o.out_free  = out_free;
  assign sts_o.list_done = (count_q == '0) || ({1'b0, idx_q} + 1'b1 == count_q);
  assign sts_o.count     = count_q;

  assign out_valid_o  = ov_q;
  assign out_status_o = ost_q;
  assign out_low_o    = olo_q;
  assign out_high_o   = ohi_q;
  assign out_count_o  = ocnt_q;
  assign out_last_o   = olast_q;

endmodule

// ===== hw/rtl/disjoint_interval_set_top.sv =====
// Top level of the disjoint interval set block: stream ports, controller
// and datapath. Depends on dis_pkg, dis_ctrl, dis_datapath and the assert header.
`timescale 1ns / 1ps

// The block holds up to 32 disjoint, non-touching closed intervals of 16-bit
// values in ascending order. tuser on the input selects the command: 0 adds
// tdata, 1 lists the table. An add goes through its input transfer, a compare
// step in which every stored entry is compared with the value in parallel
// and the outcome is registered, and an update step in which the table
// shifts and the result is loaded into the output register. A list takes its
// transfer and the compare step and then gives one result per cycle while
// the output register is free, walking through the table. A result that
// waits in the output register holds back the table update of an add, or
// the next list entry, for as long as it waits. The next input transfer is
// taken once the previous item has loaded its final result, even while that
// result still waits in the output register. Each add gives one result with
// tlast set; a list gives one result per interval, tlast on the last, or a
// single empty marker. The table has no reset; only the interval count is
// cleared, so no clearing pass is needed.

`include "disjoint_interval_set_top_assert.svh"

module disjoint_interval_set_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [15:0] value
  input  logic [0:0]  s_tuser_i,   // [0] command
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [15:0] interval_low, [31:16] interval_high,
                                   // [37:32] interval_count, [39:38] zero
  output logic [2:0]  m_tuser_o,   // [2:0] status
  output logic        m_tlast_o
);
  import dis_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [ValueBits-1:0] out_low, out_high;
  logic [CntW-1:0]      out_count;

  dis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dis_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (s_tuser_i[0]),
    .in_value_i   (s_tdata_i),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_status_o (m_tuser_o),
    .out_low_o    (out_low),
    .out_high_o   (out_high),
    .out_count_o  (out_count),
    .out_last_o   (m_tlast_o)
  );

  // Results are packed with the lower end in the lowest bits.
  assign m_tdata_o = {2'b00, out_count, out_high, out_low};

  // The stored count never exceeds the table size.
  `DIS_ASSERT_IMP(a_count_range, 1'b1, sts.count <= CntW'(MaxIntervals))
  // An accepted item blocks the input for at least the following cycle.
  `DIS_ASSERT_NXT(a_one_item, s_tvalid_i && s_tready_o, !s_tready_o)
  // Every add result, and the empty list marker, is the only one of its item.
  `DIS_ASSERT_IMP(a_add_last, m_tvalid_o && (m_tuser_o != ST_LIST), m_tlast_o)
  // The controller never loads a result while one is held and not taken.
  `DIS_ASSERT_IMP(a_no_overrun, (cmd.commit || cmd.list_load), sts.out_free)

endmodule
